@@ rtl/core/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants and types for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int unsigned OPERAND_WIDTH_DEFAULT = 32;
   localparam int unsigned RESULT_WIDTH = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL,
      ST_SQR,
      ST_DONE
   } state_type;

endpackage

@@ rtl/core/modexp_cell.sv @@
// ----------------------------------------------------------------------------
// modexp_cell
// One bit cell of the modular multiplier: holds one accumulator bit and one
// bit of the modular-add carry chain, handing carry and borrow to its neighbour.
// ----------------------------------------------------------------------------
module modexp_cell import modexp_pkg::*; (
   input  logic clock,
   input  logic load,      // clear accumulator bit
   input  logic update,    // take new accumulator bit
   input  logic dbl_bit,   // bit of the doubled accumulator (acc << 1, reduced mod m)
   input  logic add_bit,   // bit of the addend (a when multiplier bit set)
   input  logic mod_bit,   // bit of the modulus
   input  logic carry_in,
   input  logic borrow_in,
   output logic carry_out,
   output logic borrow_out,
   output logic sum_bit,
   output logic diff_bit,
   input  logic sel_diff,
   output logic acc_bit
);

   logic acc_ff;
   logic acc_in;
   logic s;

   // sum of doubled acc and addend, then trial subtraction of the modulus
   assign s          = dbl_bit ^ add_bit ^ carry_in;
   assign carry_out  = (dbl_bit & add_bit) | (carry_in & (dbl_bit ^ add_bit));
   assign diff_bit   = s ^ mod_bit ^ borrow_in;
   assign borrow_out = (~s & mod_bit) | (borrow_in & ~(s ^ mod_bit));
   assign sum_bit    = s;

   always_comb begin
      acc_in = acc_ff;
      if (load) begin
         acc_in = 1'b0;
      end else if (update) begin
         acc_in = sel_diff ? diff_bit : sum_bit;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_bit = acc_ff;

endmodule

@@ rtl/core/modexp_mul.sv @@
// ----------------------------------------------------------------------------
// modexp_mul
// Bit-serial modular multiplier built from a row of bit cells. Each busy cycle
// computes acc = 2*acc + b_i*a mod m, scanning b from the top bit.
// ----------------------------------------------------------------------------
module modexp_mul import modexp_pkg::*; #(
   parameter int unsigned W = OPERAND_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] op_a,
   input  logic [W-1:0] op_b,
   input  logic [W-1:0] modulus,
   output logic         done,
   output logic [W-1:0] product
);

   localparam int unsigned CW = $clog2(W + 1);
   localparam int unsigned EW = W + 2;

   logic [W-1:0]  a_ff, b_ff, m_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   logic [W-1:0]  acc;
   logic [EW-1:0] dbl, add, mext;
   logic [EW:0]   carry, borrow;
   logic [EW-1:0] sum_bits, diff_bits, acc_ext;
   logic          sel_diff;
   logic          step;

   assign step = busy_ff;
   assign acc_ext = {2'b00, acc};
   assign dbl  = {acc_ext[EW-2:0], 1'b0};
   assign add  = b_ff[W-1] ? {2'b00, a_ff} : '0;
   assign mext = {2'b00, m_ff};
   assign carry[0]  = 1'b0;
   assign borrow[0] = 1'b0;

   // 2*acc + a < 3m could need two subtractions; the double is pre-reduced
   // below so that dbl_red + a < 2m and one trial subtraction suffices
   logic [EW-1:0] dbl_red;
   assign dbl_red = (dbl >= mext) ? dbl - mext : dbl;

   genvar g;
   generate
      for (g = 0; g < EW; g++) begin : g_cell
         logic acc_bit_w;
         modexp_cell u_cell (
            .clock      (clock),
            .load       (start),
            .update     (step),
            .dbl_bit    (dbl_red[g]),
            .add_bit    (add[g]),
            .mod_bit    (mext[g]),
            .carry_in   (carry[g]),
            .borrow_in  (borrow[g]),
            .carry_out  (carry[g+1]),
            .borrow_out (borrow[g+1]),
            .sum_bit    (sum_bits[g]),
            .diff_bit   (diff_bits[g]),
            .sel_diff   (sel_diff),
            .acc_bit    (acc_bit_w)
         );
         if (g < W) begin : g_acc
            assign acc[g] = acc_bit_w;
         end
      end
   endgenerate

   // no borrow out means sum >= m
   assign sel_diff = ~borrow[EW];

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
         m_ff <= modulus;
      end else if (busy_ff) begin
         b_ff <= {b_ff[W-2:0], 1'b0};
      end
   end

   assign done    = done_ff;
   assign product = acc;

endmodule

@@ rtl/core/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply modular exponentiation on a bit-serial
// multiplier made of a row of bit cells.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  request  | req_valid/ready, req_base/exponent/modulus | in
//  response | rsp_valid/ready, rsp_power_result       | out
//
// One item at a time. The base is reduced first through the multiplier
// (times one), then each exponent bit up to the top set bit costs a check
// state plus a square, and a set bit a multiply more. Synchronous reset
// clears control. A stalled response holds in its register and the next
// request is taken only once it has been delivered.
// ----------------------------------------------------------------------------
module modular_exponentiation import modexp_pkg::*; #(
   parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [31:0]             req_base,
   input  logic [31:0]             req_exponent,
   input  logic [31:0]             req_modulus,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RESULT_WIDTH-1:0] rsp_power_result
);

   localparam int unsigned W = OPERAND_WIDTH;

   state_type state_ff, state_in;
   logic [W-1:0] x_ff, y_ff, m_ff, acc_ff;
   logic [RESULT_WIDTH-1:0] res_ff;
   logic rsp_valid_ff;

   logic         mul_start, mul_done;
   logic [W-1:0] mul_a, mul_b, mul_p, mul_m;
   logic [W-1:0] in_x, in_y, in_m;
   logic         take;

   // fields wider than W: keep the low W bits; narrower: zero-extend
   assign in_x = W'({32'd0, req_base}     & {{32{1'b0}}, 32'hFFFF_FFFF});
   assign in_y = W'({32'd0, req_exponent} & {{32{1'b0}}, 32'hFFFF_FFFF});
   assign in_m = W'({32'd0, req_modulus}  & {{32{1'b0}}, 32'hFFFF_FFFF});

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign take      = req_valid && req_ready;

   modexp_mul #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (mul_m),
      .done    (mul_done),
      .product (mul_p)
   );

   always_comb begin
      state_in  = state_ff;
      mul_start = 1'b0;
      mul_a     = x_ff;
      mul_b     = x_ff;
      mul_m     = m_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (in_y == '0 || in_m == '0) state_in = ST_DONE;
               else                          state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            // x mod m via x*1 is wrong for x >= m in the cells, so reduce by
            // repeated doubling: 1 * x scanning x bits gives x mod m
            mul_a = W'(1);
            mul_b = x_ff;
            if (mul_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (y_ff == '0) begin
               state_in = ST_DONE;
            end else if (y_ff[0]) begin
               state_in  = ST_MUL;
               mul_start = 1'b1;
               mul_a     = x_ff;
               mul_b     = acc_ff;
            end else begin
               state_in  = ST_SQR;
               mul_start = 1'b1;
            end
         end
         ST_MUL: begin
            mul_a = x_ff;
            mul_b = acc_ff;
            if (mul_done) begin
               state_in  = ST_SQR;
               mul_start = 1'b1;
               mul_a     = x_ff;
               mul_b     = x_ff;
            end
         end
         ST_SQR: begin
            if (mul_done) state_in = ST_CHECK;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // the modulus register is loaded at this same edge, so feed the port
      if (state_ff == ST_IDLE && take && in_y != '0 && in_m != '0) begin
         mul_start = 1'b1;
         mul_a     = (in_m == W'(1)) ? '0 : W'(1);
         mul_b     = in_x;
         mul_m     = in_m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         x_ff   <= in_x;
         y_ff   <= in_y;
         m_ff   <= in_m;
         acc_ff <= (in_m == W'(1)) ? '0 : W'(1);
         res_ff <= (in_y == '0) ? RESULT_WIDTH'(1) : '0;
      end else begin
         if (state_ff == ST_REDUCE && mul_done) x_ff <= mul_p;
         if (state_ff == ST_MUL && mul_done)    acc_ff <= mul_p;
         if (state_ff == ST_SQR && mul_done) begin
            x_ff <= mul_p;
            y_ff <= y_ff >> 1;
         end
         if (state_ff == ST_CHECK && y_ff == '0) res_ff <= RESULT_WIDTH'(acc_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = res_ff;

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid) else $error("result not raised");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_power_result))
      else $error("result changed under stall");

endmodule

@@ tb/tb_modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for the modular exponentiation block: directed edge
// cases, then random beats, each response compared with a typed result or a
// square-and-multiply predictor, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_modular_exponentiation import modexp_pkg::*;;

   localparam int N_RANDOM   = 250;
   localparam int WATCH_MAX  = 20000;
   localparam int HOLD_LEN   = 6000;

   typedef struct {
      logic [31:0] base;
      logic [31:0] exponent;
      logic [31:0] modulus;
      bit          known;
      logic [31:0] result;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_base = '0;
   logic [31:0] req_exponent = '0;
   logic [31:0] req_modulus = 32'd1;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [RESULT_WIDTH-1:0] rsp_power_result;

   logic [31:0] expected_powers[$];
   row_type     table_rows[$];
   int          errors = 0;
   int          n_sent = 0;
   int          n_got = 0;
   int          idle_cnt = 0;
   bit          quiet = 1'b0;
   bit          hold_on = 1'b0;
   bit          hold_done = 1'b0;

   always #5 clock = ~clock;

   modular_exponentiation dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_base(req_base), .req_exponent(req_exponent), .req_modulus(req_modulus),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_power_result(rsp_power_result)
   );

   function automatic logic [31:0] mulmod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return 32'(p % 64'(m));
   endfunction

   function automatic logic [31:0] power_mod(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] m);
      logic [31:0] acc;
      logic [31:0] sq;
      logic [31:0] e;
      if (y == 0) return 32'd1;
      if (m == 0) return 32'd0;
      acc = 32'd1 % m;
      sq = x % m;
      e = y;
      while (e != 0) begin
         if (e[0]) acc = mulmod(acc, sq, m);
         sq = mulmod(sq, sq, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic row_type mk(logic [31:0] b, logic [31:0] e, logic [31:0] m,
                                  bit k = 0, logic [31:0] r = 0);
      row_type t;
      t.base = b; t.exponent = e; t.modulus = m; t.known = k; t.result = r;
      return t;
   endfunction

   function automatic logic [31:0] rand_exponent();
      // mostly short exponents keep the run brief, a few full width
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'hFFFF_FFFF;
         default: return 32'($urandom) >> $urandom_range(31, 20);
      endcase
   endfunction

   // called at a falling edge; leaves valid high so the next beat can follow
   task automatic send(logic [31:0] b, logic [31:0] e, logic [31:0] m);
      while (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_base <= b; req_exponent <= e; req_modulus <= m; req_valid <= 1'b1;
      expected_powers.push_back(power_mod(b, e, m));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
      @(negedge clock);
   endtask

   // response side: random idling, one long hold-off
   always @(negedge clock) begin
      if (hold_on) rsp_ready <= 1'b0;
      else rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_got++;
         if (expected_powers.size() == 0) begin
            errors++;
            $display("%0t: unexpected response %h", $time, rsp_power_result);
         end else begin
            logic [31:0] want;
            want = expected_powers.pop_front();
            if (rsp_power_result !== want) begin
               errors++;
               $display("%0t: power_result expected %h actual %h",
                        $time, want, rsp_power_result);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCH_MAX) begin
         $display("watchdog: no beat for %0d cycles", WATCH_MAX);
         $display("tb_modular_exponentiation: FAIL");
         $finish;
      end
   end

   initial begin
      table_rows.push_back(mk(32'd5, 32'd0, 32'd1, 1, 32'd1));
      table_rows.push_back(mk(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1, 32'd1));
      table_rows.push_back(mk(32'd0, 32'd0, 32'd7, 1, 32'd1));
      table_rows.push_back(mk(32'd5, 32'd3, 32'd0, 1, 32'd0));
      table_rows.push_back(mk(32'd123, 32'd5, 32'd1, 1, 32'd0));
      table_rows.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1, 32'd0));
      table_rows.push_back(mk(32'd0, 32'd9, 32'd13, 1, 32'd0));
      table_rows.push_back(mk(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd1));
      table_rows.push_back(mk(32'd7, 32'd1, 32'd100, 1, 32'd7));
      table_rows.push_back(mk(32'd107, 32'd1, 32'd100, 1, 32'd7));
      table_rows.push_back(mk(32'd2, 32'd10, 32'd100000, 1, 32'd1024));
      table_rows.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      table_rows.push_back(mk(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      table_rows.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB));
      table_rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0001));
      table_rows.push_back(mk(32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFFF));
      table_rows.push_back(mk(32'd3, 32'h8000_0000, 32'd1_000_000_007));
      table_rows.push_back(mk(32'd5, 32'd3, 32'd2));
      table_rows.push_back(mk(32'd13, 32'hAAAA_AAAA, 32'h5555_5555));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (table_rows[i]) begin
         if (table_rows[i].known && power_mod(table_rows[i].base,
               table_rows[i].exponent, table_rows[i].modulus) != table_rows[i].result)
            $display("table row %0d: predictor disagrees with typed value", i);
         send(table_rows[i].base, table_rows[i].exponent, table_rows[i].modulus);
         if (table_rows[i].known) expected_powers[$] = table_rows[i].result;
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         logic [31:0] m;
         if (n == 60) begin
            // sender pauses until the block has drained
            req_valid <= 1'b0;
            wait (expected_powers.size() == 0);
            @(negedge clock);
         end
         if (n == 100) fork
            begin
               hold_on = 1'b1;
               repeat (HOLD_LEN) @(negedge clock);
               hold_on = 1'b0;
               hold_done = 1'b1;
            end
         join_none
         quiet = (n >= 150 && n < 190);
         m = $urandom;
         if ($urandom_range(7) == 0) m = 32'($urandom_range(3) + 1);
         if (m == 0) m = 32'd1;
         send($urandom, rand_exponent(), m);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      wait (hold_done && expected_powers.size() == 0);
      repeat (100) @(posedge clock);
      $display("sent %0d requests (%0d directed), received %0d responses",
               n_sent, table_rows.size(), n_got);
      $display("covered zero exponent, zero and unit modulus, full-width operands, long stalls");
      if (errors == 0 && expected_powers.size() == 0)
         $display("tb_modular_exponentiation: PASS");
      else
         $display("tb_modular_exponentiation: FAIL");
      $finish;
   end

endmodule
